// ----- rtl/rcre_pkg.sv -----
// Shared constants, codes and structs of the read coverage run encoder.
`timescale 1ns / 1ps

package rcre_pkg;

    // Window geometry
    localparam int WINDOW_BASES = 65536;
    localparam int OFF_W        = $clog2(WINDOW_BASES);
    localparam int CNT_W        = OFF_W + 1;

    // Field widths
    localparam int OP_W     = 2;
    localparam int POS_W    = 31;
    localparam int WEIGHT_W = 32;
    localparam int CODE_W   = 4;
    localparam int LEN_W    = 28;
    localparam int CUR_W    = 32;
    localparam int EXT_W    = CUR_W + 1;
    localparam int VAL_W    = 64;
    localparam int STAT_W   = 2;

    // Request operations
    typedef enum logic [OP_W-1:0] {
        OP_BUNDLE = 2'd0,
        OP_READ   = 2'd1,
        OP_CIGAR  = 2'd2,
        OP_FETCH  = 2'd3
    } op_t;

    // CIGAR operation codes
    localparam logic [CODE_W-1:0] CIGAR_M = CODE_W'(0);
    localparam logic [CODE_W-1:0] CIGAR_I = CODE_W'(1);
    localparam logic [CODE_W-1:0] CIGAR_D = CODE_W'(2);
    localparam logic [CODE_W-1:0] CIGAR_N = CODE_W'(3);
    localparam logic [CODE_W-1:0] CIGAR_S = CODE_W'(4);

    // Result status
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_CODE  = 2'd1,
        STAT_OUTSIDE   = 2'd2,
        STAT_SATURATED = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RANGE,
        S_CLIP,
        S_PREP,
        S_MATCH,
        S_SCAN,
        S_CLEAR,
        S_DONE
    } state_t;

    // One result
    typedef struct packed {
        logic               run_valid;
        logic [POS_W-1:0]   run_start;
        logic [POS_W-1:0]   run_end;
        logic [VAL_W-1:0]   run_value;
        logic               flush_done;
        status_t            status;
    } res_t;

    // Coverage memory access
    typedef struct packed {
        logic               we;
        logic [OFF_W-1:0]   waddr;
        logic [VAL_W-1:0]   wdata;
        logic [OFF_W-1:0]   raddr;
    } mem_req_t;

endpackage

// ----- rtl/rcre_if.sv -----
// Request and result channel interfaces of the read coverage run encoder.
`timescale 1ns / 1ps

interface rcre_in_if;
    import rcre_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [POS_W-1:0]       position;
    logic [WEIGHT_W-1:0]    weight;
    logic [CODE_W-1:0]      cigar_code;
    logic [LEN_W-1:0]       cigar_length;

    modport source (
        output valid, operation, position, weight, cigar_code, cigar_length,
        input  ready
    );
    modport sink (
        input  valid, operation, position, weight, cigar_code, cigar_length,
        output ready
    );
endinterface

interface rcre_out_if;
    import rcre_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   run_valid;
    logic [POS_W-1:0]       run_start;
    logic [POS_W-1:0]       run_end;
    logic [VAL_W-1:0]       run_value;
    logic                   flush_done;
    logic [STAT_W-1:0]      status;

    modport source (
        output valid, run_valid, run_start, run_end, run_value, flush_done, status,
        input  ready
    );
    modport sink (
        input  valid, run_valid, run_start, run_end, run_value, flush_done, status,
        output ready
    );
endinterface

// ----- rtl/rcre_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module rcre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [WIDTH-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/rcre_ctrl.sv -----
// Sequencer and datapath: decodes requests, walks the coverage memory, builds results.
`timescale 1ns / 1ps

module rcre_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    rcre_in_if.sink                     cmd,
    output rcre_pkg::mem_req_t          mem_req,
    input  logic [rcre_pkg::VAL_W-1:0]  mem_rdata,
    output rcre_pkg::res_t              res,
    output logic                        res_push,
    input  logic                        res_ready
);
    import rcre_pkg::*;

    state_t                 state_reg, state_next;

    // Captured request
    op_t                    cmd_op_reg;
    logic [POS_W-1:0]       cmd_pos_reg;
    logic [WEIGHT_W-1:0]    cmd_weight_reg;
    logic [CODE_W-1:0]      cmd_code_reg;
    logic [LEN_W-1:0]       cmd_len_reg;

    // Architectural state
    logic [POS_W-1:0]       window_base_reg, window_base_next;
    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;
    logic [CNT_W-1:0]       hw_reg, hw_next;
    logic [CNT_W-1:0]       scan_reg, scan_next;

    // Walk control
    logic [CNT_W-1:0]       ra_reg, ra_next;
    logic [CNT_W-1:0]       end_reg, end_next;
    logic                   dv_reg, dv_next;
    logic                   found_reg, found_next;
    logic                   sat_reg, sat_next;
    logic                   init_reg, init_next;

    // Working values
    logic [EXT_W-1:0]       hi_reg, hi_next;
    logic [CUR_W-1:0]       whi_reg, whi_next;
    logic [EXT_W-1:0]       a_reg, a_next;
    logic [EXT_W-1:0]       b_reg, b_next;
    logic [OFF_W-1:0]       da_reg, da_next;
    logic [VAL_W-1:0]       val_reg, val_next;
    logic [OFF_W-1:0]       start_reg, start_next;

    // Result under construction
    logic                   res_run_valid_reg, res_run_valid_next;
    logic                   res_flush_reg, res_flush_next;
    logic [POS_W-1:0]       res_start_reg, res_start_next;
    logic [POS_W-1:0]       res_end_reg, res_end_next;
    status_t                res_status_reg, res_status_next;

    // Combinational helpers
    logic                   issue;
    logic                   term;
    logic [CNT_W-1:0]       run_end_off;
    logic [EXT_W-1:0]       lo_ext;
    logic [EXT_W-1:0]       wlo_ext;
    logic [EXT_W-1:0]       adv;
    logic [EXT_W-1:0]       span;
    logic [EXT_W-1:0]       off_lo;
    logic [EXT_W-1:0]       off_hi;
    logic [VAL_W:0]         sum_ext;

    assign cmd.ready = (state_reg == S_IDLE);

    assign lo_ext  = {1'b0, cursor_reg};
    assign wlo_ext = EXT_W'(window_base_reg);
    assign issue   = (ra_reg != end_reg);
    assign adv     = lo_ext + EXT_W'(cmd_len_reg);
    assign span    = b_reg - a_reg;
    assign off_lo  = a_reg - wlo_ext;
    assign off_hi  = b_reg - wlo_ext;
    assign sum_ext = {1'b0, mem_rdata} + (VAL_W + 1)'(weight_reg);

    assign res.run_valid  = res_run_valid_reg;
    assign res.run_start  = res_start_reg;
    assign res.run_end    = res_end_reg;
    assign res.run_value  = val_reg;
    assign res.flush_done = res_flush_reg;
    assign res.status     = res_status_reg;

    assign res_push = (state_reg == S_DONE) && res_ready;

    // Next state and datapath
    always_comb
    begin
        state_next         = state_reg;
        window_base_next   = window_base_reg;
        cursor_next        = cursor_reg;
        weight_next        = weight_reg;
        hw_next            = hw_reg;
        scan_next          = scan_reg;
        ra_next            = ra_reg;
        end_next           = end_reg;
        dv_next            = dv_reg;
        found_next         = found_reg;
        sat_next           = sat_reg;
        init_next          = init_reg;
        hi_next            = hi_reg;
        whi_next           = whi_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        da_next            = da_reg;
        val_next           = val_reg;
        start_next         = start_reg;
        res_run_valid_next = res_run_valid_reg;
        res_flush_next     = res_flush_reg;
        res_start_next     = res_start_reg;
        res_end_next       = res_end_reg;
        res_status_next    = res_status_reg;
        term               = 1'b0;
        run_end_off        = end_reg;
        mem_req.we         = 1'b0;
        mem_req.waddr      = da_reg;
        mem_req.wdata      = '0;
        mem_req.raddr      = ra_reg[OFF_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_run_valid_next = 1'b0;
                res_flush_next     = 1'b0;
                res_start_next     = '0;
                res_end_next       = '0;
                res_status_next    = STAT_OK;
                val_next           = '0;
                state_next         = S_DONE;
                case (cmd_op_reg)
                    OP_BUNDLE:
                    begin
                        // Restart window, wipe everything written so far
                        window_base_next = cmd_pos_reg;
                        hw_next          = '0;
                        scan_next        = '0;
                        ra_next          = '0;
                        end_next         = hw_reg;
                        state_next       = S_CLEAR;
                    end
                    OP_READ:
                    begin
                        cursor_next = CUR_W'(cmd_pos_reg);
                        weight_next = cmd_weight_reg;
                    end
                    OP_CIGAR:
                    begin
                        case (cmd_code_reg)
                            CIGAR_M:
                            begin
                                state_next = S_RANGE;
                            end
                            CIGAR_D, CIGAR_N:
                            begin
                                cursor_next = adv[CUR_W] ? '1 : adv[CUR_W-1:0];
                            end
                            CIGAR_I, CIGAR_S:
                            begin
                                cursor_next = cursor_reg;
                            end
                            default:
                            begin
                                res_status_next = STAT_BAD_CODE;
                            end
                        endcase
                    end
                    OP_FETCH:
                    begin
                        ra_next    = scan_reg;
                        end_next   = hw_reg;
                        dv_next    = 1'b0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Span of the match and the window end
            S_RANGE:
            begin
                hi_next    = adv;
                whi_next   = {1'b0, window_base_reg} + CUR_W'(WINDOW_BASES);
                state_next = S_CLIP;
            end

            // Clip the span to the window
            S_CLIP:
            begin
                a_next     = (lo_ext > wlo_ext) ? lo_ext : wlo_ext;
                b_next     = (hi_reg < {1'b0, whi_reg}) ? hi_reg : {1'b0, whi_reg};
                state_next = S_PREP;
            end

            // Flag clipped parts, set up the walk, advance the cursor
            S_PREP:
            begin
                cursor_next = hi_reg[CUR_W] ? '1 : hi_reg[CUR_W-1:0];
                if (b_reg <= a_reg)
                begin
                    res_status_next = (cmd_len_reg != '0) ? STAT_OUTSIDE : STAT_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    res_status_next = (span != EXT_W'(cmd_len_reg)) ? STAT_OUTSIDE : STAT_OK;
                    ra_next         = off_lo[CNT_W-1:0];
                    end_next        = off_hi[CNT_W-1:0];
                    dv_next         = 1'b0;
                    sat_next        = 1'b0;
                    state_next      = S_MATCH;
                end
            end

            // Read one entry per cycle, write back the sum in the cycle after its read
            S_MATCH:
            begin
                if (issue)
                begin
                    ra_next = ra_reg + CNT_W'(1);
                end
                dv_next = issue;
                da_next = ra_reg[OFF_W-1:0];
                if (dv_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = sum_ext[VAL_W] ? '1 : sum_ext[VAL_W-1:0];
                    if (sum_ext[VAL_W])
                    begin
                        sat_next = 1'b1;
                    end
                end
                if (!issue && !dv_reg)
                begin
                    if (end_reg > hw_reg)
                    begin
                        hw_next = end_reg;
                    end
                    if (res_status_reg == STAT_OK && sat_reg)
                    begin
                        res_status_next = STAT_SATURATED;
                    end
                    state_next = S_DONE;
                end
            end

            // Skip zeros, then collect and clear one run of equal values
            S_SCAN:
            begin
                if (issue)
                begin
                    ra_next = ra_reg + CNT_W'(1);
                end
                dv_next = issue;
                da_next = ra_reg[OFF_W-1:0];
                if (dv_reg)
                begin
                    if (!found_reg)
                    begin
                        if (mem_rdata != '0)
                        begin
                            found_next = 1'b1;
                            val_next   = mem_rdata;
                            start_next = da_reg;
                            mem_req.we = 1'b1;
                        end
                    end
                    else if (mem_rdata == val_reg)
                    begin
                        mem_req.we = 1'b1;
                    end
                    else
                    begin
                        term        = 1'b1;
                        run_end_off = CNT_W'(da_reg);
                    end
                end
                else if (!issue)
                begin
                    term = 1'b1;
                end
                if (term)
                begin
                    scan_next          = run_end_off;
                    res_run_valid_next = found_reg;
                    res_flush_next     = !found_reg;
                    res_start_next     = found_reg ?
                                         window_base_reg + POS_W'(start_reg) : '0;
                    res_end_next       = found_reg ?
                                         window_base_reg + POS_W'(run_end_off) : '0;
                    state_next         = S_DONE;
                end
            end

            // Zero entries one per cycle
            S_CLEAR:
            begin
                if (issue)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = ra_reg[OFF_W-1:0];
                    ra_next       = ra_reg + CNT_W'(1);
                end
                else if (init_reg)
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // Hand the result over once the output stage has room
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts the memory clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            window_base_reg <= '0;
            cursor_reg      <= '0;
            weight_reg      <= '0;
            hw_reg          <= '0;
            scan_reg        <= '0;
            ra_reg          <= '0;
            end_reg         <= CNT_W'(WINDOW_BASES);
            dv_reg          <= 1'b0;
            found_reg       <= 1'b0;
            sat_reg         <= 1'b0;
            init_reg        <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            window_base_reg <= window_base_next;
            cursor_reg      <= cursor_next;
            weight_reg      <= weight_next;
            hw_reg          <= hw_next;
            scan_reg        <= scan_next;
            ra_reg          <= ra_next;
            end_reg         <= end_next;
            dv_reg          <= dv_next;
            found_reg       <= found_next;
            sat_reg         <= sat_next;
            init_reg        <= init_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_op_reg     <= op_t'(cmd.operation);
            cmd_pos_reg    <= cmd.position;
            cmd_weight_reg <= cmd.weight;
            cmd_code_reg   <= cmd.cigar_code;
            cmd_len_reg    <= cmd.cigar_length;
        end
        hi_reg            <= hi_next;
        whi_reg           <= whi_next;
        a_reg             <= a_next;
        b_reg             <= b_next;
        da_reg            <= da_next;
        val_reg           <= val_next;
        start_reg         <= start_next;
        res_run_valid_reg <= res_run_valid_next;
        res_flush_reg     <= res_flush_next;
        res_start_reg     <= res_start_next;
        res_end_reg       <= res_end_next;
        res_status_reg    <= res_status_next;
    end

    // Read-modify-write never reads the entry it writes in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MATCH || state_reg == S_SCAN) && mem_req.we)
            |-> (mem_req.waddr != mem_req.raddr))
        else $error("coverage walk reads the entry it writes");

    // Flush cursor never passes the written extent
    assert property (@(posedge clk) disable iff (!rst_n) scan_reg <= hw_reg)
        else $error("flush cursor beyond written extent");

    // Written extent stays inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        hw_reg <= CNT_W'(WINDOW_BASES))
        else $error("written extent beyond window");

    // An accepted request is decoded next
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    // Results are pushed only into a free output stage, and only from DONE
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (state_reg == S_IDLE))
        else $error("result pushed without returning to idle");

endmodule

// ----- rtl/rcre_out_stage.sv -----
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module rcre_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rcre_pkg::res_t  res,
    output logic            ready,
    rcre_out_if.source      rsp
);
    import rcre_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign ready = !valid_reg || rsp.ready;

    // Fill on push, drain on downstream accept
    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.run_valid  = res_reg.run_valid;
    assign rsp.run_start  = res_reg.run_start;
    assign rsp.run_end    = res_reg.run_end;
    assign rsp.run_value  = res_reg.run_value;
    assign rsp.flush_done = res_reg.flush_done;
    assign rsp.status     = res_reg.status;

endmodule

// ----- rtl/read_coverage_run_encoder_core.sv -----
// Top level of the read coverage run encoder: sequencer, coverage memory, output register.
`timescale 1ns / 1ps

// Accumulates per-base read coverage over a window of 65536 reference positions held in
// one single-port-write, registered-read memory, and returns it as runs of equal nonzero
// coverage. Requests are handled one at a time; every request yields exactly one result.
// After reset the block first zeroes the whole memory and takes no request until that is
// done. A begin-read, an I/S/D/N CIGAR element or an unknown code is decoded and then
// handed to the output register. An M element computes its span, clips it to the window
// and sets up the walk, then updates each base that falls in the window with one
// read-modify-write of the memory per cycle. A fetch scans entries from the flush cursor
// up to the end of the returned run. A new bundle zeroes one entry per cycle, up to the
// highest position written in the previous window, through the one memory write port.
// A finished result waits in the output register while the next request is already
// being processed.
module read_coverage_run_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    rcre_in_if.sink     cmd,
    rcre_out_if.source  rsp
);
    import rcre_pkg::*;

    mem_req_t           mem_req;
    logic [VAL_W-1:0]   mem_rdata;
    res_t               res;
    logic               res_push;
    logic               res_ready;

    rcre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res       (res),
        .res_push  (res_push),
        .res_ready (res_ready)
    );

    rcre_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WINDOW_BASES)
    ) u_cov_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    rcre_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .res   (res),
        .ready (res_ready),
        .rsp   (rsp)
    );

endmodule
